// ----- rtl/core/scmap_pkg.sv -----
// Package for the scalar-to-RGB colormap block.
// Holds the fixed field widths, the map codes, the register map and the RGB result type.
// Depends on nothing; every other file of the block refers to it by scoped names.
package scmap_pkg;

    // Fixed widths of the request and result fields.
    localparam int SAMPLE_W = 14;
    localparam int CHAN_W   = 8;

    // Configuration port geometry.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int MAP_SEL_W  = 3;

    // Register indexes (word addresses).
    localparam logic [APB_ADDR_W-3:0] REG_MAP_SELECT = '0;

    // Colormap codes; the remaining codes select black.
    typedef enum logic [MAP_SEL_W-1:0] {
        MAP_RAINBOW   = 3'd0,
        MAP_GRAY      = 3'd1,
        MAP_TWO_HUE   = 3'd2,
        MAP_HEAT      = 3'd3,
        MAP_DIVERGING = 3'd4
    } t_map_sel;

    // One result: three saturated 8-bit channels.
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

endpackage

// ----- rtl/core/scmap_sample_if.sv -----
// Input channel of the colormap block: valid/ready handshake and one scalar sample.
// Depends on scmap_pkg for the sample width.
interface scmap_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [scmap_pkg::SAMPLE_W-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

// ----- rtl/core/scmap_rgb_if.sv -----
// Output channel of the colormap block: valid/ready handshake and one RGB triple.
// Depends on scmap_pkg for the channel width.
interface scmap_rgb_if;
    logic                          valid;
    logic                          ready;
    logic [scmap_pkg::CHAN_W-1:0]  red;
    logic [scmap_pkg::CHAN_W-1:0]  green;
    logic [scmap_pkg::CHAN_W-1:0]  blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- rtl/core/scmap_cfg.sv -----
// APB-style register file of the colormap block: holds the map selector.
// Depends on scmap_pkg for the register map and port widths.
module scmap_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [scmap_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [scmap_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [scmap_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready,
    output logic [scmap_pkg::MAP_SEL_W-1:0]    o_map_select
);

    logic [scmap_pkg::MAP_SEL_W-1:0] r_map_select;
    logic                            hit;

    // The word index is the address above the byte offset.
    assign hit    = (paddr[scmap_pkg::APB_ADDR_W-1:2] == scmap_pkg::REG_MAP_SELECT);
    assign pready = 1'b1;

    // Register write in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_select <= scmap_pkg::MAP_RAINBOW;
        end else if (psel && penable && pwrite && hit) begin
            r_map_select <= pwdata[scmap_pkg::MAP_SEL_W-1:0];
        end
    end

    // Read back; unmapped words read as zero.
    always_comb begin
        prdata = '0;
        if (hit) begin
            prdata[scmap_pkg::MAP_SEL_W-1:0] = r_map_select;
        end
    end

    assign o_map_select = r_map_select;

endmodule

// ----- rtl/core/scmap_core.sv -----
// Combinational colormap datapath: clamps one sample and evaluates the selected map.
// Depends on scmap_pkg for the map codes and the RGB result type.
module scmap_core #(
    parameter int FRAC_BITS = 12
) (
    input  logic signed [scmap_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [scmap_pkg::MAP_SEL_W-1:0]       i_map_select,
    output scmap_pkg::t_rgb                       o_rgb
);

    // Working width holds 5103 * 1.0 with a sign bit.
    localparam int AW = FRAC_BITS + 14;
    // Width of a value after dropping the fraction bits.
    localparam int VW = 13;

    localparam logic signed [AW-1:0] ONE  = AW'(1 << FRAC_BITS);
    localparam logic signed [AW-1:0] UNIT = AW'(5 << FRAC_BITS);

    logic signed [AW-1:0] sx;
    logic signed [AW-1:0] x;
    logic signed [AW-1:0] gs;
    logic signed [AW-1:0] q4;
    logic signed [AW-1:0] hr;
    logic signed [AW-1:0] hg;
    logic signed [AW-1:0] hb;
    logic [7:0]           rb_r;
    logic [7:0]           rb_g;
    logic [7:0]           rb_b;
    logic [7:0]           gray;
    logic [7:0]           th_up;
    logic [7:0]           th_down;
    logic [7:0]           heat_r;
    logic [7:0]           heat_g;
    logic [7:0]           dv_rise;
    logic [7:0]           dv_r;
    logic [7:0]           dv_b;
    logic [7:0]           dv_g4;

    function automatic logic signed [AW-1:0] f_abs(input logic signed [AW-1:0] v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [AW-1:0] f_pos(input logic signed [AW-1:0] v);
        return (v < 0) ? '0 : v;
    endfunction

    function automatic logic [7:0] f_sat(input logic [VW-1:0] v);
        return (v > VW'(255)) ? 8'd255 : v[7:0];
    endfunction

    // Integer part of a nonnegative working value.
    function automatic logic [VW-1:0] f_int(input logic signed [AW-1:0] m);
        logic signed [AW-1:0] s;
        s = m >>> FRAC_BITS;
        return s[VW-1:0];
    endfunction

    // Round for a denominator of 1.0: m already carries the half, divide by 2.0.
    function automatic logic [7:0] f_rnd_one(input logic signed [AW-1:0] m);
        logic signed [AW-1:0] s;
        s = m >>> (FRAC_BITS + 1);
        return (m < 0) ? 8'd0 : f_sat(s[VW-1:0]);
    endfunction

    // Divide by 10 through a reciprocal, exact for v below 16384.
    function automatic logic [7:0] f_div10(input logic [VW-1:0] v);
        logic [VW+12:0] p;
        p = (VW+13)'(v) * (VW+13)'(6554);
        return f_sat(VW'(p >> 16));
    endfunction

    // Divide by 6 through a reciprocal, exact for v below 32768.
    function automatic logic [7:0] f_div6(input logic [VW-1:0] v);
        logic [VW+13:0] p;
        p = (VW+14)'(v) * (VW+14)'(10923);
        return f_sat(VW'(p >> 16));
    endfunction

    // Divide by 14 through a reciprocal, exact for v below 5400.
    function automatic logic [7:0] f_div14(input logic [VW-1:0] v);
        logic [VW+12:0] p;
        p = (VW+13)'(v) * (VW+13)'(4682);
        return f_sat(VW'(p >> 16));
    endfunction

    // Rainbow channel: round(255 * h / (10 * 1.0)).
    function automatic logic [7:0] f_rb(input logic signed [AW-1:0] h);
        logic signed [AW-1:0] m;
        m = (h <<< 8) - h + UNIT;
        return f_div10(f_int(m));
    endfunction

    // Clamp the sample to [0, 1.0].
    assign sx = AW'(i_sample);
    always_comb begin
        if (sx < 0) begin
            x = '0;
        end else if (sx > ONE) begin
            x = ONE;
        end else begin
            x = sx;
        end
    end

    // Rainbow hats over g scaled by five units of 1.0.
    assign gs = x * AW'(22) + (ONE <<< 2);
    assign hr = f_pos(UNIT * AW'(3) - f_abs(gs - UNIT * AW'(4)) - f_abs(gs - UNIT * AW'(5)));
    assign hg = f_pos(UNIT * AW'(4) - f_abs(gs - UNIT * AW'(2)) - f_abs(gs - UNIT * AW'(4)));
    assign hb = f_pos(UNIT * AW'(3) - f_abs(gs - UNIT) - f_abs(gs - UNIT * AW'(2)));
    assign rb_r = f_rb(hr);
    assign rb_g = f_rb(hg);
    assign rb_b = f_rb(hb);

    // Grayscale and the two-hue ramps (denominator 1.0, half added up front).
    assign gray    = f_rnd_one(x * AW'(510) + ONE);
    assign th_up   = f_rnd_one(x * AW'(1020) + ONE);
    assign th_down = f_rnd_one(ONE * AW'(511) - x * AW'(1020));

    // Heat: red ramp up to 0.3, then green ramp over the remaining 0.7.
    assign heat_r = f_div6(f_int(x * AW'(5100) + ONE * AW'(3)));
    assign heat_g = f_div14(f_int(x * AW'(5100) - ONE * AW'(1523)));

    // Diverging segments over q = 4 f.
    assign q4      = x <<< 2;
    assign dv_rise = f_rnd_one(x * AW'(2040) + ONE);
    assign dv_r    = f_rnd_one(x * AW'(2040) - ONE * AW'(509));
    assign dv_b    = f_rnd_one(ONE * AW'(1531) - x * AW'(2040));
    assign dv_g4   = f_rnd_one(ONE * AW'(2041) - x * AW'(2040));

    // Select the map.
    always_comb begin
        o_rgb = '0;
        case (i_map_select)
            scmap_pkg::MAP_RAINBOW: begin
                o_rgb.red   = rb_r;
                o_rgb.green = rb_g;
                o_rgb.blue  = rb_b;
            end
            scmap_pkg::MAP_GRAY: begin
                o_rgb.red   = gray;
                o_rgb.green = gray;
                o_rgb.blue  = gray;
            end
            scmap_pkg::MAP_TWO_HUE: begin
                if (q4 < ONE) begin
                    o_rgb.red   = th_up;
                    o_rgb.green = th_down;
                end else begin
                    o_rgb.red   = th_down;
                    o_rgb.green = th_up;
                end
            end
            scmap_pkg::MAP_HEAT: begin
                if (x * AW'(10) <= ONE * AW'(3)) begin
                    o_rgb.red = heat_r;
                end else begin
                    o_rgb.red   = 8'd255;
                    o_rgb.green = heat_g;
                end
            end
            scmap_pkg::MAP_DIVERGING: begin
                if (q4 <= ONE) begin
                    o_rgb.green = dv_rise;
                    o_rgb.blue  = 8'd255;
                end else if (q4 <= ONE * AW'(2)) begin
                    o_rgb.red   = dv_r;
                    o_rgb.green = 8'd255;
                    o_rgb.blue  = 8'd255;
                end else if (q4 <= ONE * AW'(3)) begin
                    o_rgb.red   = 8'd255;
                    o_rgb.green = 8'd255;
                    o_rgb.blue  = dv_b;
                end else begin
                    o_rgb.red   = 8'd255;
                    o_rgb.green = dv_g4;
                end
            end
            default: begin
                o_rgb = '0;
            end
        endcase
    end

endmodule

// ----- rtl/core/scalar_to_rgb_colormap.sv -----
// Scalar-to-RGB colormap, top level: input register, colormap datapath, result register.
// Depends on scmap_pkg, scmap_sample_if, scmap_rgb_if, scmap_cfg and scmap_core.
//
// The block takes one signed sample per clock while the output is not stalled and returns
// one RGB triple per sample, in order. A request is registered at acceptance, mapped in a
// single combinational pass and held in the result register, which takes it from the
// input register whenever the result register is empty or its result is being taken;
// throughput is one item per clock while the output is not stalled, set by the two register
// stages, each of which advances whenever the stage after it is empty or being drained.
// Select the colormap through the map_select register at address 0 only while no request
// is in flight. FRAC_BITS sets the number of fraction bits of the sample.
module scalar_to_rgb_colormap #(
    parameter int FRAC_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    scmap_sample_if.sink                      i_sample,
    scmap_rgb_if.source                       o_rgb,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [scmap_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [scmap_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [scmap_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);

    logic [scmap_pkg::MAP_SEL_W-1:0]        map_select;
    logic                                   r_v1;
    logic signed [scmap_pkg::SAMPLE_W-1:0]  r_sample;
    logic                                   r_v2;
    scmap_pkg::t_rgb                        r_rgb;
    scmap_pkg::t_rgb                        n_rgb;
    logic                                   adv1;
    logic                                   take_in;

    scmap_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_map_select (map_select)
    );

    scmap_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_sample     (r_sample),
        .i_map_select (map_select),
        .o_rgb        (n_rgb)
    );

    // Stage handshakes: each stage moves when the one after it has room.
    assign adv1             = r_v1 && (!r_v2 || o_rgb.ready);
    assign i_sample.ready   = !r_v1 || adv1;
    assign take_in          = i_sample.valid && i_sample.ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_sample.ready) begin
            r_v1 <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_sample <= i_sample.sample_value;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (!r_v2 || o_rgb.ready) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_rgb.valid = r_v2;
    assign o_rgb.red   = r_rgb.red;
    assign o_rgb.green = r_rgb.green;
    assign o_rgb.blue  = r_rgb.blue;

    // An accepted request occupies the input register in the next cycle.
    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_in |=> r_v1)
        else $error("accepted request did not reach the input register");

    // A request stuck behind a full, stalled result register keeps its sample.
    a_hold_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !adv1) |=> (r_v1 && $stable(r_sample)))
        else $error("stalled input register lost its sample");

    // A request moved out of the input register shows up as a valid result.
    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv1 |=> r_v2)
        else $error("mapped request did not reach the result register");

    // A stalled result holds its value.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !o_rgb.ready) |=> (r_v2 && $stable(r_rgb)))
        else $error("stalled result changed");

endmodule

// ----- tb/scalar_to_rgb_colormap_tb.sv -----
// Self-checking testbench for scalar_to_rgb_colormap: random and corner-case samples under
// every map code, with an in-bench colormap predictor and in-order RGB result checking.
// Depends on scmap_pkg, scmap_sample_if, scmap_rgb_if and the RTL of the block.
module scalar_to_rgb_colormap_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS      = 12;
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 3;
    localparam int DRAIN_SETTLE   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD_OFF  = 150;
    localparam int PHASE_COUNT    = 12;
    localparam int PHASE_ITEMS    = 77;

    // Field and port widths of the block.
    localparam int SAMPLE_W   = scmap_pkg::SAMPLE_W;
    localparam int CHAN_W     = scmap_pkg::CHAN_W;
    localparam int MAP_SEL_W  = scmap_pkg::MAP_SEL_W;
    localparam int APB_ADDR_W = scmap_pkg::APB_ADDR_W;
    localparam int APB_DATA_W = scmap_pkg::APB_DATA_W;

    // Selector codes outside the enum; all of them produce black.
    localparam logic [MAP_SEL_W-1:0] MAP_SPARE_LO  = MAP_SEL_W'(scmap_pkg::MAP_DIVERGING + 1);
    localparam logic [MAP_SEL_W-1:0] MAP_SPARE_MID = MAP_SEL_W'(scmap_pkg::MAP_DIVERGING + 2);
    localparam logic [MAP_SEL_W-1:0] MAP_SPARE_HI  = '1;

    localparam logic [APB_ADDR_W-1:0] MAP_SELECT_ADDR = {scmap_pkg::REG_MAP_SELECT, 2'b00};

    // Idle patterns applied in rotation over the random phases.
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct {
        logic [MAP_SEL_W-1:0] map;
        int                   value;
    } t_directed;

    // Sample values sitting on clamp edges, segment edges and rainbow hat corners.
    localparam int CORNER_COUNT = 24;
    localparam int CORNER_VALUES [CORNER_COUNT] = '{
        0, 1, 186, 187, 1023, 1024, 1025, 1117, 1118, 1228, 1229, 2047,
        2048, 2049, 2978, 2979, 3071, 3072, 3073, 3909, 3910, 4095, 4096, 4097
    };

    localparam logic [MAP_SEL_W-1:0] PHASE_MAP [PHASE_COUNT] = '{
        scmap_pkg::MAP_DIVERGING, scmap_pkg::MAP_RAINBOW, scmap_pkg::MAP_HEAT,
        scmap_pkg::MAP_GRAY, scmap_pkg::MAP_TWO_HUE, MAP_SPARE_HI,
        scmap_pkg::MAP_RAINBOW, scmap_pkg::MAP_DIVERGING, scmap_pkg::MAP_HEAT,
        MAP_SPARE_MID, scmap_pkg::MAP_TWO_HUE, scmap_pkg::MAP_GRAY
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    scmap_sample_if sample_ch ();
    scmap_rgb_if    rgb_ch ();

    scalar_to_rgb_colormap #(
        .FRAC_BITS(FRAC_BITS)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch),
        .o_rgb    (rgb_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shared bench state.
    logic signed [SAMPLE_W-1:0] pending_samples [$];
    scmap_pkg::t_rgb            rgb_expected [$];
    logic [MAP_SEL_W-1:0]       map_select_model;
    int                         src_idle_pct;
    int                         snk_stall_pct;
    int                         error_count;
    int                         samples_sent;
    int                         results_seen;
    int                         quiet_cycles;
    int                         long_stall_reqs;
    int                         long_stall_done;
    int                         hold_left;

    always #CLK_HALF i_clk = ~i_clk;

    // Round num/den to nearest with halves up, then saturate to 0..255.
    function automatic logic [CHAN_W-1:0] round_sat(input longint num, input longint den);
        longint q;
        if (num <= 0) begin
            return '0;
        end
        q = (2 * num + den) / (2 * den);
        if (q > 255) begin
            q = 255;
        end
        return CHAN_W'(q);
    endfunction

    function automatic longint abs_l(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint floor_zero(input longint v);
        return (v < 0) ? 0 : v;
    endfunction

    // Expected RGB triple for one sample under the given map code.
    function automatic scmap_pkg::t_rgb colormap_pixel(input logic [MAP_SEL_W-1:0] sel,
                                                       input logic signed [SAMPLE_W-1:0] sample);
        longint          one;
        longint          x;
        longint          u;
        longint          gs;
        longint          q;
        scmap_pkg::t_rgb px;
        one = longint'(1) << FRAC_BITS;
        x   = longint'(sample);
        if (x < 0) begin
            x = 0;
        end
        if (x > one) begin
            x = one;
        end
        px = '0;
        case (sel)
            scmap_pkg::MAP_RAINBOW: begin
                // Hats over g = 4.4f + 0.8, with g scaled by 5*one.
                u  = 5 * one;
                gs = 22 * x + 4 * one;
                px.red   = round_sat(255 * floor_zero(3 * u - abs_l(gs - 4 * u)
                                     - abs_l(gs - 5 * u)), 2 * u);
                px.green = round_sat(255 * floor_zero(4 * u - abs_l(gs - 2 * u)
                                     - abs_l(gs - 4 * u)), 2 * u);
                px.blue  = round_sat(255 * floor_zero(3 * u - abs_l(gs - u)
                                     - abs_l(gs - 2 * u)), 2 * u);
            end
            scmap_pkg::MAP_GRAY: begin
                px.red   = round_sat(255 * x, one);
                px.green = px.red;
                px.blue  = px.red;
            end
            scmap_pkg::MAP_TWO_HUE: begin
                if (4 * x < one) begin
                    px.red   = round_sat(255 * 2 * x, one);
                    px.green = round_sat(255 * (one - 2 * x), one);
                end else begin
                    px.red   = round_sat(255 * (one - 2 * x), one);
                    px.green = round_sat(255 * 2 * x, one);
                end
            end
            scmap_pkg::MAP_HEAT: begin
                // The 0.3 point itself still belongs to the red ramp.
                if (10 * x <= 3 * one) begin
                    px.red = round_sat(2550 * x, 3 * one);
                end else begin
                    px.red   = 8'd255;
                    px.green = round_sat(255 * (10 * x - 3 * one), 7 * one);
                end
            end
            scmap_pkg::MAP_DIVERGING: begin
                // Segment edges belong to the lower segment.
                q = 4 * x;
                if (q <= one) begin
                    px.green = round_sat(255 * q, one);
                    px.blue  = 8'd255;
                end else if (q <= 2 * one) begin
                    px.red   = round_sat(255 * (q - one), one);
                    px.green = 8'd255;
                    px.blue  = 8'd255;
                end else if (q <= 3 * one) begin
                    px.red   = 8'd255;
                    px.green = 8'd255;
                    px.blue  = round_sat(255 * (3 * one - q), one);
                end else begin
                    px.red   = 8'd255;
                    px.green = round_sat(255 * (4 * one - q), one);
                end
            end
            default: begin
                px = '0;
            end
        endcase
        return px;
    endfunction

    // Mostly in-range values, a share of corner values and some full-range noise.
    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        int roll;
        roll = $urandom_range(99);
        if (roll < 20) begin
            return SAMPLE_W'(CORNER_VALUES[$urandom_range(CORNER_COUNT - 1)]);
        end else if (roll < 35) begin
            return SAMPLE_W'($urandom);
        end
        return SAMPLE_W'($urandom_range(1 << FRAC_BITS));
    endfunction

    // Sample driver: offers the pending queue, predicts each request at acceptance.
    always @(posedge i_clk) begin : sample_driver
        if (!i_rst_n) begin
            sample_ch.valid <= 1'b0;
        end else begin
            if (sample_ch.valid && sample_ch.ready) begin
                rgb_expected.push_back(colormap_pixel(map_select_model,
                                                      sample_ch.sample_value));
                samples_sent++;
            end
            if (!sample_ch.valid || sample_ch.ready) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    sample_ch.valid        <= 1'b1;
                    sample_ch.sample_value <= pending_samples.pop_front();
                end else begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each accepted triple and drives ready, with long hold-offs.
    always @(posedge i_clk) begin : rgb_monitor
        scmap_pkg::t_rgb want;
        if (!i_rst_n) begin
            rgb_ch.ready <= 1'b0;
        end else begin
            if (rgb_ch.valid && rgb_ch.ready) begin
                results_seen++;
                if (rgb_expected.size() == 0) begin
                    $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
                             rgb_ch.red, rgb_ch.green, rgb_ch.blue);
                    error_count++;
                end else begin
                    want = rgb_expected.pop_front();
                    if (rgb_ch.red !== want.red) begin
                        $display("%0t: red mismatch, expected %0d, got %0d", $time,
                                 want.red, rgb_ch.red);
                        error_count++;
                    end
                    if (rgb_ch.green !== want.green) begin
                        $display("%0t: green mismatch, expected %0d, got %0d", $time,
                                 want.green, rgb_ch.green);
                        error_count++;
                    end
                    if (rgb_ch.blue !== want.blue) begin
                        $display("%0t: blue mismatch, expected %0d, got %0d", $time,
                                 want.blue, rgb_ch.blue);
                        error_count++;
                    end
                end
            end
            if (long_stall_reqs != long_stall_done) begin
                long_stall_done++;
                hold_left = LONG_HOLD_OFF;
            end
            if (hold_left > 0) begin
                hold_left--;
                rgb_ch.ready <= 1'b0;
            end else begin
                rgb_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // Watchdog: ends the run when no request moves on either channel for too long.
    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((sample_ch.valid && sample_ch.ready) || (rgb_ch.valid && rgb_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
                $display("FAILED: results differ");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Wait until every sample is accepted and every result has come back.
    task automatic wait_until_drained();
        do @(negedge i_clk);
        while (pending_samples.size() != 0 || sample_ch.valid || rgb_expected.size() != 0);
        repeat (DRAIN_SETTLE) @(posedge i_clk);
    endtask

    // Write map_select over the configuration port, then read it back.
    task automatic write_map_select(input logic [MAP_SEL_W-1:0] sel);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAP_SELECT_ADDR;
        pwdata  <= APB_DATA_W'(sel);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        map_select_model = sel;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== APB_DATA_W'(sel)) begin
            $display("%0t: map_select readback mismatch, expected %0d, got %0d", $time,
                     sel, prdata);
            error_count++;
        end
        do @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_idle_mode(input t_idle_mode mode);
        case (mode)
            IDLE_SENDER: begin
                src_idle_pct  = 56;
                snk_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                src_idle_pct  = 0;
                snk_stall_pct = 56;
            end
            IDLE_BOTH: begin
                src_idle_pct  = 16;
                snk_stall_pct = 16;
            end
            default: begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
        endcase
    endtask

    // Stimulus: reset, corner cases per map, then random phases over all map codes but code 5.
    initial begin : stimulus
        t_directed directed_cases [$];
        logic [MAP_SEL_W-1:0] active_map;
        int half;

        i_rst_n                = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.sample_value = '0;
        rgb_ch.ready           = 1'b0;
        map_select_model       = scmap_pkg::MAP_RAINBOW;
        src_idle_pct           = 0;
        snk_stall_pct          = 0;
        error_count            = 0;
        samples_sent           = 0;
        results_seen           = 0;
        quiet_cycles           = 0;
        long_stall_reqs        = 0;
        long_stall_done        = 0;
        hold_left              = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Rainbow first, under the reset value of map_select: clamps and hat corners.
        directed_cases.push_back('{scmap_pkg::MAP_RAINBOW, -8192});
        directed_cases.push_back('{scmap_pkg::MAP_RAINBOW, 0});
        directed_cases.push_back('{scmap_pkg::MAP_RAINBOW, 186});
        directed_cases.push_back('{scmap_pkg::MAP_RAINBOW, 187});
        directed_cases.push_back('{scmap_pkg::MAP_RAINBOW, 1117});
        directed_cases.push_back('{scmap_pkg::MAP_RAINBOW, 2979});
        directed_cases.push_back('{scmap_pkg::MAP_RAINBOW, 3910});
        directed_cases.push_back('{scmap_pkg::MAP_RAINBOW, 4096});
        directed_cases.push_back('{scmap_pkg::MAP_RAINBOW, 8191});
        directed_cases.push_back('{scmap_pkg::MAP_GRAY, -1});
        directed_cases.push_back('{scmap_pkg::MAP_GRAY, 1});
        directed_cases.push_back('{scmap_pkg::MAP_GRAY, 4097});
        // Two-hue crossover at one quarter.
        directed_cases.push_back('{scmap_pkg::MAP_TWO_HUE, 1023});
        directed_cases.push_back('{scmap_pkg::MAP_TWO_HUE, 1024});
        // Heat: the 0.3 point stays in the red ramp.
        directed_cases.push_back('{scmap_pkg::MAP_HEAT, 1228});
        directed_cases.push_back('{scmap_pkg::MAP_HEAT, 1229});
        directed_cases.push_back('{scmap_pkg::MAP_HEAT, 4096});
        // Diverging segment edges belong to the lower segment.
        directed_cases.push_back('{scmap_pkg::MAP_DIVERGING, 1024});
        directed_cases.push_back('{scmap_pkg::MAP_DIVERGING, 1025});
        directed_cases.push_back('{scmap_pkg::MAP_DIVERGING, 2048});
        directed_cases.push_back('{scmap_pkg::MAP_DIVERGING, 3072});
        directed_cases.push_back('{scmap_pkg::MAP_DIVERGING, 3073});
        directed_cases.push_back('{scmap_pkg::MAP_DIVERGING, 4096});
        directed_cases.push_back('{MAP_SPARE_LO, 2048});

        active_map = scmap_pkg::MAP_RAINBOW;
        foreach (directed_cases[i]) begin
            if (directed_cases[i].map != active_map) begin
                wait_until_drained();
                active_map = directed_cases[i].map;
                write_map_select(active_map);
            end
            pending_samples.push_back(SAMPLE_W'(directed_cases[i].value));
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_until_drained();
            write_map_select(PHASE_MAP[phase]);
            set_idle_mode(t_idle_mode'(phase % 4));
            half = PHASE_ITEMS / 2;
            for (int n = 0; n < half; n++) begin
                pending_samples.push_back(random_sample());
            end
            if (phase == 4) begin
                // Output held off while the sender keeps offering, to back up the pipe.
                long_stall_reqs++;
            end
            if (phase == 6) begin
                // Sender pauses mid-phase until every result is back.
                wait_until_drained();
            end
            for (int n = half; n < PHASE_ITEMS; n++) begin
                pending_samples.push_back(random_sample());
            end
        end

        wait_until_drained();
        repeat (DRAIN_SETTLE) @(posedge i_clk);

        $display("Run sent %0d samples and checked %0d RGB results over all eight map codes,",
                 samples_sent, results_seen);
        $display("with corner samples, mixed idle and stall patterns and a long output hold-off.");
        if (error_count == 0 && rgb_expected.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
